>>> rtl/ctd_pkg.sv
// shared types, constants and the byte classifier of the chunked transfer decoder
// no dependencies
`default_nettype none

package ctd_pkg;

	localparam int SIZE_BITS_DEF  = 32;
	localparam int LINE_LIMIT_DEF = 31;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;

	typedef enum logic [2:0] {
		CL_CR,
		CL_LF,
		CL_SEMI,
		CL_BLANK,
		CL_HEX,
		CL_OTHER
	} char_class_t;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_DATA,
		PH_CR,
		PH_LF,
		PH_DONE,
		PH_ERR
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	// one classified byte as it travels from front to back
	typedef struct packed {
		logic [7:0]  data;
		char_class_t cls;
		logic [3:0]  nibble;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic item_t classify(input logic [7:0] c);
		item_t it;
		it.data   = c;
		it.nibble = 4'd0;
		it.cls    = CL_OTHER;
		if (c == CHAR_CR) begin
			it.cls = CL_CR;
		end else if (c == CHAR_LF) begin
			it.cls = CL_LF;
		end else if (c == CHAR_SEMI) begin
			it.cls = CL_SEMI;
		end else if (c == CHAR_SPACE || c == CHAR_TAB) begin
			it.cls = CL_BLANK;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			it.cls    = CL_HEX;
			it.nibble = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			// letters a-f and A-F share the low three bits
			it.cls    = CL_HEX;
			it.nibble = 4'd9 + {1'b0, c[2:0]};
		end
		return it;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ctd_front.sv
// front part: accepts input bytes and classifies them into queue items
// depends on ctd_pkg
`default_nettype none

module ctd_front (
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      data_byte,
	input  wire ctd_pkg::q_stat_t q_stat,
	output logic                 push,
	output ctd_pkg::item_t       push_item
);
	import ctd_pkg::*;

	assign in_ready  = !q_stat.full;
	assign push      = in_valid && !q_stat.full;
	assign push_item = classify(data_byte);

endmodule

`default_nettype wire

>>> rtl/ctd_queue.sv
// two-entry queue of classified items between front and back
// depends on ctd_pkg
`default_nettype none

module ctd_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ctd_pkg::item_t   push_item,
	input  wire logic             pop,
	output ctd_pkg::item_t        head_item,
	output ctd_pkg::q_stat_t      q_stat
);
	import ctd_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	assign head_item    = slot_q[rd_ptr_q];
	assign q_stat.full  = count_q[1];
	assign q_stat.empty = (count_q == 2'd0);

endmodule

`default_nettype wire

>>> rtl/ctd_back.sv
// back part: decode state machine and registered result stage
// depends on ctd_pkg
`default_nettype none

module ctd_back #(
	parameter int SIZE_BITS  = ctd_pkg::SIZE_BITS_DEF,
	parameter int LINE_LIMIT = ctd_pkg::LINE_LIMIT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ctd_pkg::item_t   head_item,
	input  wire ctd_pkg::q_stat_t q_stat,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  payload_valid,
	output logic [7:0]            payload_byte,
	output logic                  chunk_end,
	output logic [1:0]            decode_status
);
	import ctd_pkg::*;

	localparam int LC_W = $clog2(LINE_LIMIT + 1);
	localparam logic [LC_W-1:0] LC_LIMIT = LC_W'(LINE_LIMIT);

	phase_t               phase_q, phase_d;
	logic [SIZE_BITS-1:0] size_q, size_d;
	logic [SIZE_BITS-1:0] remain_q, remain_d;
	logic [LC_W-1:0]      lc_q, lc_d;
	logic                 seen_q, seen_d;
	logic                 stop_q, stop_d;
	logic                 bad_q, bad_d;

	logic                 pv_d, ce_d;
	logic [7:0]           pb_d;
	status_t              st_d;

	logic                 out_valid_q;
	logic                 pv_q, ce_q;
	logic [7:0]           pb_q;
	status_t              st_q;

	assign pop = !q_stat.empty && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		phase_d  = phase_q;
		size_d   = size_q;
		remain_d = remain_q;
		lc_d     = lc_q;
		seen_d   = seen_q;
		stop_d   = stop_q;
		bad_d    = bad_q;
		unique case (phase_q)
			PH_SIZE: begin
				if (head_item.cls == CL_CR) begin
					// ignored, not counted
				end else if (head_item.cls == CL_LF) begin
					if (bad_q || !seen_q) begin
						phase_d = PH_ERR;
					end else begin
						size_d = '0;
						lc_d   = '0;
						seen_d = 1'b0;
						stop_d = 1'b0;
						bad_d  = 1'b0;
						if (size_q == '0) begin
							phase_d = PH_DONE;
						end else begin
							remain_d = size_q;
							phase_d  = PH_DATA;
						end
					end
				end else if (lc_q >= LC_LIMIT) begin
					phase_d = PH_ERR;
				end else begin
					lc_d = lc_q + LC_W'(1);
					if (!stop_q && !bad_q) begin
						case (head_item.cls)
							CL_SEMI: stop_d = 1'b1;
							CL_HEX: begin
								if (size_q[SIZE_BITS-1 -: 4] != 4'd0) begin
									bad_d = 1'b1;
								end else begin
									size_d = {size_q[SIZE_BITS-5:0], head_item.nibble};
									seen_d = 1'b1;
								end
							end
							CL_BLANK: begin
								if (seen_q) begin
									stop_d = 1'b1;
								end
							end
							default: bad_d = 1'b1;
						endcase
					end
				end
			end
			PH_DATA: begin
				if (remain_q != '0) begin
					remain_d = remain_q - SIZE_BITS'(1);
				end
				if (remain_d == '0) begin
					phase_d = PH_CR;
				end
			end
			PH_CR: phase_d = (head_item.cls == CL_CR) ? PH_LF : PH_ERR;
			PH_LF: begin
				if (head_item.cls == CL_LF) begin
					phase_d = PH_SIZE;
					size_d  = '0;
					lc_d    = '0;
					seen_d  = 1'b0;
					stop_d  = 1'b0;
					bad_d   = 1'b0;
				end else begin
					phase_d = PH_ERR;
				end
			end
			PH_DONE: phase_d = PH_DONE;
			default: phase_d = PH_ERR;
		endcase
	end

	// outputs of this item
	always_comb begin
		pv_d = (phase_q == PH_DATA);
		pb_d = pv_d ? head_item.data : 8'd0;
		ce_d = pv_d && (phase_d == PH_CR);
		unique case (phase_d)
			PH_DONE: st_d = ST_DONE;
			PH_ERR:  st_d = ST_ERROR;
			default: st_d = ST_BUSY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE;
			size_q      <= '0;
			remain_q    <= '0;
			lc_q        <= '0;
			seen_q      <= 1'b0;
			stop_q      <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (pop) begin
			phase_q     <= phase_d;
			size_q      <= size_d;
			remain_q    <= remain_d;
			lc_q        <= lc_d;
			seen_q      <= seen_d;
			stop_q      <= stop_d;
			bad_q       <= bad_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pv_q <= pv_d;
			pb_q <= pb_d;
			ce_q <= ce_d;
			st_q <= st_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_valid = pv_q;
	assign payload_byte  = pb_q;
	assign chunk_end     = ce_q;
	assign decode_status = st_q;

endmodule

`default_nettype wire

>>> rtl/http_chunked_transfer_decoder_unit.sv
// top level of the chunked transfer decoder: front, item queue and back
// depends on ctd_pkg, ctd_front, ctd_queue, ctd_back
`default_nettype none

// Decodes an HTTP/1.1 chunked body, one byte per input item, one result item
// per input item. Each result carries the payload flag, the payload byte (zero
// when not payload), a last-byte-of-chunk flag and the sticky decode status
// (in progress, done after the zero-size chunk, error). Sustained rate is one
// item per cycle while the output is not stalled; an accepted item is written
// into the two-entry item queue, and when the back part takes it from the head
// its state update writes the output register. A stalled output fills the
// queue, then drops in_ready; the input side never waits on the output side
// while the queue has room. SIZE_BITS sets the largest chunk size taken,
// LINE_LIMIT the longest size line (CR and LF not counted).

module http_chunked_transfer_decoder_unit #(
	parameter int SIZE_BITS  = ctd_pkg::SIZE_BITS_DEF,
	parameter int LINE_LIMIT = ctd_pkg::LINE_LIMIT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            payload_valid,
	output logic [7:0]      payload_byte,
	output logic            chunk_end,
	output logic [1:0]      decode_status
);
	import ctd_pkg::*;

	// front to queue
	logic    push;
	item_t   push_item;
	// queue to back
	item_t   head_item;
	q_stat_t q_stat;
	logic    pop;

	// classification of each byte: CR, LF, semicolon, blank, hex digit, other
	ctd_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	// decouples accept from execution so each side stalls on its own
	ctd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_stat    (q_stat)
	);

	// size-line parse, data count, trailer check and sticky done/error
	ctd_back #(
		.SIZE_BITS  (SIZE_BITS),
		.LINE_LIMIT (LINE_LIMIT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_item     (head_item),
		.q_stat        (q_stat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.chunk_end     (chunk_end),
		.decode_status (decode_status)
	);

endmodule

`default_nettype wire
